/* hdl/cmtg_pkg.sv */
package cmtg_pkg;

    localparam int DIR_W        = 16;
    localparam int EXT_W        = DIR_W + 1;
    localparam int SUM_W        = DIR_W + 2;
    localparam int RES_W        = 16;
    localparam logic [RES_W-1:0] RES_RESET = 16'd256;

    // scale by res_factor * 128, doubled for round-half-up
    localparam int RES_SHIFT    = 8;
    localparam int PROD_W       = SUM_W + RES_W;
    localparam int NUM_W        = PROD_W + RES_SHIFT;
    localparam int DVD_W        = NUM_W - 1;
    localparam int DVS_W        = EXT_W;

    localparam int COORD_W      = 32;
    localparam int TOP_W        = DVD_W - COORD_W;
    localparam logic [COORD_W-1:0] COORD_MAX = 32'h7fff_ffff;
    localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

    localparam int DIV_STEP     = 4;
    localparam int DIV_STAGES   = COORD_W / DIV_STEP;
    localparam int SCALE_STAGES = 4;
    localparam int DIV_FIRST    = 1 + SCALE_STAGES;
    localparam int N_STAGES     = 1 + SCALE_STAGES + DIV_STAGES + 1;

    localparam int FACE_W       = 3;
    localparam int N_FACES      = 6;

    typedef enum logic [FACE_W-1:0] {
        FACE_PX = 3'd0,
        FACE_NX = 3'd1,
        FACE_PY = 3'd2,
        FACE_NY = 3'd3,
        FACE_PZ = 3'd4,
        FACE_NZ = 3'd5
    } t_face;

    typedef struct packed {
        t_face                    face;
        logic signed [EXT_W-1:0]  sc;
        logic signed [EXT_W-1:0]  tc;
        logic signed [EXT_W-1:0]  ma;
    } t_sel;

    typedef struct packed {
        logic [DVD_W-1:0] a;
        logic             neg;
    } t_lane;

    typedef struct packed {
        t_face            face;
        logic             zero;
        logic [DVS_W-1:0] d;
        t_lane            u;
        t_lane            v;
    } t_scaled;

    typedef struct packed {
        logic [COORD_W-1:0] quo;
        logic               ovf;
        logic               neg;
    } t_quot;

endpackage

/* hdl/cube_map_texcoord_generator.sv */
// Throughput: one beat per clock while the output is not stalled; set by the
// 14-stage pipeline, where the two 32-bit quotients take 8 stages at 4 bits
// each. An output stall holds only the stages that have no empty stage after
// them, so empty stages still fill.
// Reset (i_rst_n low, synchronous) clears all stage valids and sets
// res_factor to 256 (1.0).
module cube_map_texcoord_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cmtg_pkg::RES_W-1:0]          i_cfg_data,

    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [cmtg_pkg::DIR_W-1:0]   i_face_dir_x,
    input  logic signed [cmtg_pkg::DIR_W-1:0]   i_face_dir_y,
    input  logic signed [cmtg_pkg::DIR_W-1:0]   i_face_dir_z,
    input  logic signed [cmtg_pkg::DIR_W-1:0]   i_vert_dir_x,
    input  logic signed [cmtg_pkg::DIR_W-1:0]   i_vert_dir_y,
    input  logic signed [cmtg_pkg::DIR_W-1:0]   i_vert_dir_z,

    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [cmtg_pkg::COORD_W-1:0] o_u_coord,
    output logic signed [cmtg_pkg::COORD_W-1:0] o_v_coord,
    output logic [cmtg_pkg::FACE_W-1:0]         o_cube_face,
    output logic                                o_zero_major
);

    localparam int LAST = cmtg_pkg::N_STAGES - 1;

    logic [cmtg_pkg::RES_W-1:0]    r_res_factor;
    logic [cmtg_pkg::N_STAGES-1:0] r_valid;
    logic [cmtg_pkg::N_STAGES-1:0] n_valid;
    logic [cmtg_pkg::N_STAGES-1:0] en;

    cmtg_pkg::t_sel                sel;
    cmtg_pkg::t_scaled             scaled;
    cmtg_pkg::t_quot               quot_u, quot_v;

    cmtg_pkg::t_face               r_side_face [cmtg_pkg::DIV_STAGES];
    logic                          r_side_zero [cmtg_pkg::DIV_STAGES];

    logic [cmtg_pkg::COORD_W-1:0]  n_u, n_v;
    logic [cmtg_pkg::COORD_W-1:0]  r_u, r_v;
    cmtg_pkg::t_face               r_face;
    logic                          r_zero;

    function automatic logic [cmtg_pkg::COORD_W-1:0] coord_out(
        input cmtg_pkg::t_quot q,
        input logic            zero
    );
        logic [cmtg_pkg::COORD_W-1:0] c;
        if (zero) begin
            c = '0;
        end else if (q.ovf || q.quo[cmtg_pkg::COORD_W-1]) begin
            c = q.neg ? cmtg_pkg::COORD_MIN : cmtg_pkg::COORD_MAX;
        end else begin
            c = q.neg ? -q.quo : q.quo;
        end
        return c;
    endfunction

    // config
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_factor <= cmtg_pkg::RES_RESET;
        end else if (i_cfg_valid) begin
            r_res_factor <= i_cfg_data;
        end
    end

    // stage k loads when it or some later stage is empty, or the output is ready
    always_comb begin
        for (int k = 0; k < cmtg_pkg::N_STAGES; k++) begin
            en[k] = i_out_ready || (|((~r_valid) >> k));
        end
    end

    assign n_valid    = {r_valid[cmtg_pkg::N_STAGES-2:0], i_in_valid};
    assign o_in_ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < cmtg_pkg::N_STAGES; k++) begin
                if (en[k]) begin
                    r_valid[k] <= n_valid[k];
                end
            end
        end
    end

    cmtg_face_sel u_face_sel (
        .i_clk        (i_clk),
        .i_en         (en[0]),
        .i_face_dir_x (i_face_dir_x),
        .i_face_dir_y (i_face_dir_y),
        .i_face_dir_z (i_face_dir_z),
        .i_vert_dir_x (i_vert_dir_x),
        .i_vert_dir_y (i_vert_dir_y),
        .i_vert_dir_z (i_vert_dir_z),
        .o_sel        (sel)
    );

    cmtg_scale u_scale (
        .i_clk        (i_clk),
        .i_en         (en[cmtg_pkg::SCALE_STAGES:1]),
        .i_res_factor (r_res_factor),
        .i_sel        (sel),
        .o_scaled     (scaled)
    );

    cmtg_div_lane u_div_u (
        .i_clk  (i_clk),
        .i_en   (en[cmtg_pkg::DIV_FIRST+cmtg_pkg::DIV_STAGES-1:cmtg_pkg::DIV_FIRST]),
        .i_lane (scaled.u),
        .i_d    (scaled.d),
        .o_quot (quot_u)
    );

    cmtg_div_lane u_div_v (
        .i_clk  (i_clk),
        .i_en   (en[cmtg_pkg::DIV_FIRST+cmtg_pkg::DIV_STAGES-1:cmtg_pkg::DIV_FIRST]),
        .i_lane (scaled.v),
        .i_d    (scaled.d),
        .o_quot (quot_v)
    );

    // face and zero flag ride alongside the divider stages
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < cmtg_pkg::DIV_STAGES; k++) begin
            if (en[cmtg_pkg::DIV_FIRST+k]) begin
                if (k == 0) begin
                    r_side_face[k] <= scaled.face;
                    r_side_zero[k] <= scaled.zero;
                end else begin
                    r_side_face[k] <= r_side_face[k-1];
                    r_side_zero[k] <= r_side_zero[k-1];
                end
            end
        end
    end

    assign n_u = coord_out(quot_u, r_side_zero[cmtg_pkg::DIV_STAGES-1]);
    assign n_v = coord_out(quot_v, r_side_zero[cmtg_pkg::DIV_STAGES-1]);

    always_ff @(posedge i_clk) begin
        if (en[LAST]) begin
            r_u    <= n_u;
            r_v    <= n_v;
            r_face <= r_side_face[cmtg_pkg::DIV_STAGES-1];
            r_zero <= r_side_zero[cmtg_pkg::DIV_STAGES-1];
        end
    end

    assign o_out_valid  = r_valid[LAST];
    assign o_u_coord    = r_u;
    assign o_v_coord    = r_v;
    assign o_cube_face  = r_face;
    assign o_zero_major = r_zero;

    a_full_when_blocked : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> ((&r_valid) && !i_out_ready))
        else $error("input blocked while pipeline has room");

    a_zero_major_coords : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_zero_major) |-> (o_u_coord == '0 && o_v_coord == '0))
        else $error("zero major beat with nonzero coordinates");

    a_empty_after_reset : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

/* hdl/cmtg_face_sel.sv */
module cmtg_face_sel (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [cmtg_pkg::DIR_W-1:0] i_face_dir_x,
    input  logic signed [cmtg_pkg::DIR_W-1:0] i_face_dir_y,
    input  logic signed [cmtg_pkg::DIR_W-1:0] i_face_dir_z,
    input  logic signed [cmtg_pkg::DIR_W-1:0] i_vert_dir_x,
    input  logic signed [cmtg_pkg::DIR_W-1:0] i_vert_dir_y,
    input  logic signed [cmtg_pkg::DIR_W-1:0] i_vert_dir_z,
    output cmtg_pkg::t_sel                    o_sel
);

    logic signed [cmtg_pkg::EXT_W-1:0] cand [cmtg_pkg::N_FACES];
    logic signed [cmtg_pkg::EXT_W-1:0] best;
    logic signed [cmtg_pkg::EXT_W-1:0] x, y, z;
    cmtg_pkg::t_face                   face;
    cmtg_pkg::t_sel                    n_sel;
    cmtg_pkg::t_sel                    r_sel;

    always_comb begin
        cand[0] = cmtg_pkg::EXT_W'(i_face_dir_x);
        cand[1] = -cmtg_pkg::EXT_W'(i_face_dir_x);
        cand[2] = cmtg_pkg::EXT_W'(i_face_dir_y);
        cand[3] = -cmtg_pkg::EXT_W'(i_face_dir_y);
        cand[4] = cmtg_pkg::EXT_W'(i_face_dir_z);
        cand[5] = -cmtg_pkg::EXT_W'(i_face_dir_z);

        // strict compare: first face wins ties, +X when nothing is positive
        best = '0;
        face = cmtg_pkg::FACE_PX;
        for (int i = 0; i < cmtg_pkg::N_FACES; i++) begin
            if (cand[i] > best) begin
                best = cand[i];
                face = cmtg_pkg::t_face'(cmtg_pkg::FACE_W'(i));
            end
        end
    end

    always_comb begin
        x = cmtg_pkg::EXT_W'(i_vert_dir_x);
        y = cmtg_pkg::EXT_W'(i_vert_dir_y);
        z = cmtg_pkg::EXT_W'(i_vert_dir_z);
        n_sel.face = face;
        unique case (face)
            cmtg_pkg::FACE_PX: begin
                n_sel.sc = -z; n_sel.tc = -y; n_sel.ma = x;
            end
            cmtg_pkg::FACE_NX: begin
                n_sel.sc = z;  n_sel.tc = -y; n_sel.ma = x;
            end
            cmtg_pkg::FACE_PY: begin
                n_sel.sc = x;  n_sel.tc = z;  n_sel.ma = y;
            end
            cmtg_pkg::FACE_NY: begin
                n_sel.sc = x;  n_sel.tc = -z; n_sel.ma = y;
            end
            cmtg_pkg::FACE_PZ: begin
                n_sel.sc = x;  n_sel.tc = -y; n_sel.ma = z;
            end
            default: begin
                n_sel.sc = -x; n_sel.tc = -y; n_sel.ma = z;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sel <= n_sel;
        end
    end

    assign o_sel = r_sel;

endmodule

/* hdl/cmtg_scale.sv */
module cmtg_scale (
    input  logic                               i_clk,
    input  logic [cmtg_pkg::SCALE_STAGES-1:0]  i_en,
    input  logic [cmtg_pkg::RES_W-1:0]         i_res_factor,
    input  cmtg_pkg::t_sel                     i_sel,
    output cmtg_pkg::t_scaled                  o_scaled
);

    // stage 1: |ma| and the offset sums
    logic [cmtg_pkg::DVS_W-1:0]          n_s1_mag, r_s1_mag;
    logic signed [cmtg_pkg::SUM_W-1:0]   n_s1_su, n_s1_sv, r_s1_su, r_s1_sv;
    cmtg_pkg::t_face                     r_s1_face;
    logic                                r_s1_zero;

    // stage 2: products with res_factor
    logic signed [cmtg_pkg::PROD_W-1:0]  res_ext, su_ext, sv_ext;
    logic signed [cmtg_pkg::PROD_W-1:0]  n_s2_pu, n_s2_pv, r_s2_pu, r_s2_pv;
    logic [cmtg_pkg::DVS_W-1:0]          r_s2_mag;
    cmtg_pkg::t_face                     r_s2_face;
    logic                                r_s2_zero;

    // stage 3: rounding numerator
    logic signed [cmtg_pkg::NUM_W-1:0]   n_s3_nu, n_s3_nv, r_s3_nu, r_s3_nv;
    logic [cmtg_pkg::DVS_W-1:0]          r_s3_mag;
    cmtg_pkg::t_face                     r_s3_face;
    logic                                r_s3_zero;

    // stage 4: magnitude dividend, floor bias folded in for negatives
    logic [cmtg_pkg::DVS_W-1:0]          dvs;
    cmtg_pkg::t_scaled                   n_s4, r_s4;

    function automatic cmtg_pkg::t_lane to_lane(
        input logic [cmtg_pkg::NUM_W-1:0] num,
        input logic [cmtg_pkg::DVS_W-1:0] d
    );
        cmtg_pkg::t_lane l;
        l.neg = num[cmtg_pkg::NUM_W-1];
        // floor of a negative quotient: ~n + d = |n| + d - 1
        if (l.neg) begin
            l.a = cmtg_pkg::DVD_W'(~num + cmtg_pkg::NUM_W'(d));
        end else begin
            l.a = cmtg_pkg::DVD_W'(num);
        end
        return l;
    endfunction

    always_comb begin
        n_s1_mag = i_sel.ma[cmtg_pkg::EXT_W-1] ? cmtg_pkg::DVS_W'(-i_sel.ma)
                                               : cmtg_pkg::DVS_W'(i_sel.ma);
        n_s1_su = cmtg_pkg::SUM_W'(i_sel.sc) + $signed({1'b0, n_s1_mag});
        n_s1_sv = cmtg_pkg::SUM_W'(i_sel.tc) + $signed({1'b0, n_s1_mag});
    end

    always_comb begin
        res_ext = $signed(cmtg_pkg::PROD_W'(i_res_factor));
        su_ext  = cmtg_pkg::PROD_W'(r_s1_su);
        sv_ext  = cmtg_pkg::PROD_W'(r_s1_sv);
        n_s2_pu = su_ext * res_ext;
        n_s2_pv = sv_ext * res_ext;
    end

    always_comb begin
        n_s3_nu = $signed({r_s2_pu, {cmtg_pkg::RES_SHIFT{1'b0}}})
                + $signed(cmtg_pkg::NUM_W'(r_s2_mag));
        n_s3_nv = $signed({r_s2_pv, {cmtg_pkg::RES_SHIFT{1'b0}}})
                + $signed(cmtg_pkg::NUM_W'(r_s2_mag));
    end

    always_comb begin
        dvs       = cmtg_pkg::DVS_W'({r_s3_mag, 1'b0});
        n_s4.face = r_s3_face;
        n_s4.zero = r_s3_zero;
        n_s4.d    = dvs;
        n_s4.u    = to_lane(r_s3_nu, dvs);
        n_s4.v    = to_lane(r_s3_nv, dvs);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s1_mag  <= n_s1_mag;
            r_s1_su   <= n_s1_su;
            r_s1_sv   <= n_s1_sv;
            r_s1_face <= i_sel.face;
            r_s1_zero <= (i_sel.ma == '0);
        end
        if (i_en[1]) begin
            r_s2_pu   <= n_s2_pu;
            r_s2_pv   <= n_s2_pv;
            r_s2_mag  <= r_s1_mag;
            r_s2_face <= r_s1_face;
            r_s2_zero <= r_s1_zero;
        end
        if (i_en[2]) begin
            r_s3_nu   <= n_s3_nu;
            r_s3_nv   <= n_s3_nv;
            r_s3_mag  <= r_s2_mag;
            r_s3_face <= r_s2_face;
            r_s3_zero <= r_s2_zero;
        end
        if (i_en[3]) begin
            r_s4 <= n_s4;
        end
    end

    assign o_scaled = r_s4;

endmodule

/* hdl/cmtg_div_lane.sv */
module cmtg_div_lane (
    input  logic                              i_clk,
    input  logic [cmtg_pkg::DIV_STAGES-1:0]   i_en,
    input  cmtg_pkg::t_lane                   i_lane,
    input  logic [cmtg_pkg::DVS_W-1:0]        i_d,
    output cmtg_pkg::t_quot                   o_quot
);

    logic [cmtg_pkg::DVS_W-1:0]   r_rem [cmtg_pkg::DIV_STAGES];
    logic [cmtg_pkg::DVS_W-1:0]   r_d   [cmtg_pkg::DIV_STAGES];
    logic [cmtg_pkg::COORD_W-1:0] r_quo [cmtg_pkg::DIV_STAGES];
    logic                         r_ovf [cmtg_pkg::DIV_STAGES];
    logic                         r_neg [cmtg_pkg::DIV_STAGES];

    logic [cmtg_pkg::DVS_W-1:0]   n_rem [cmtg_pkg::DIV_STAGES];
    logic [cmtg_pkg::DVS_W-1:0]   n_d   [cmtg_pkg::DIV_STAGES];
    logic [cmtg_pkg::COORD_W-1:0] n_quo [cmtg_pkg::DIV_STAGES];
    logic                         n_ovf [cmtg_pkg::DIV_STAGES];
    logic                         n_neg [cmtg_pkg::DIV_STAGES];

    logic [cmtg_pkg::TOP_W-1:0]   a_top;
    logic [cmtg_pkg::DVS_W-1:0]   rem, d;
    logic [cmtg_pkg::COORD_W-1:0] quo;
    logic [cmtg_pkg::DVS_W:0]     trial;

    // restoring division, DIV_STEP quotient bits per stage
    always_comb begin
        a_top = i_lane.a[cmtg_pkg::DVD_W-1:cmtg_pkg::COORD_W];
        rem   = '0;
        d     = '0;
        quo   = '0;
        trial = '0;
        for (int k = 0; k < cmtg_pkg::DIV_STAGES; k++) begin
            if (k == 0) begin
                rem      = cmtg_pkg::DVS_W'(a_top);
                d        = i_d;
                quo      = i_lane.a[cmtg_pkg::COORD_W-1:0];
                // quotient needs more than COORD_W bits
                n_ovf[k] = (cmtg_pkg::DVS_W'(a_top) >= i_d);
                n_neg[k] = i_lane.neg;
            end else begin
                rem      = r_rem[k-1];
                d        = r_d[k-1];
                quo      = r_quo[k-1];
                n_ovf[k] = r_ovf[k-1];
                n_neg[k] = r_neg[k-1];
            end
            for (int j = 0; j < cmtg_pkg::DIV_STEP; j++) begin
                trial = {rem, quo[cmtg_pkg::COORD_W-1]};
                quo   = {quo[cmtg_pkg::COORD_W-2:0], 1'b0};
                if (trial >= {1'b0, d}) begin
                    rem    = cmtg_pkg::DVS_W'(trial - {1'b0, d});
                    quo[0] = 1'b1;
                end else begin
                    rem = trial[cmtg_pkg::DVS_W-1:0];
                end
            end
            n_rem[k] = rem;
            n_d[k]   = d;
            n_quo[k] = quo;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < cmtg_pkg::DIV_STAGES; k++) begin
            if (i_en[k]) begin
                r_rem[k] <= n_rem[k];
                r_d[k]   <= n_d[k];
                r_quo[k] <= n_quo[k];
                r_ovf[k] <= n_ovf[k];
                r_neg[k] <= n_neg[k];
            end
        end
    end

    assign o_quot.quo = r_quo[cmtg_pkg::DIV_STAGES-1];
    assign o_quot.ovf = r_ovf[cmtg_pkg::DIV_STAGES-1];
    assign o_quot.neg = r_neg[cmtg_pkg::DIV_STAGES-1];

endmodule

/* bench/cube_map_texcoord_generator_tb.sv */
module cube_map_texcoord_generator_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct {
        logic signed [cmtg_pkg::COORD_W-1:0] u;
        logic signed [cmtg_pkg::COORD_W-1:0] v;
        cmtg_pkg::t_face                     face;
        logic                                zero;
    } t_coord;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [cmtg_pkg::RES_W-1:0]          i_cfg_data = '0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_ready;
    logic signed [cmtg_pkg::DIR_W-1:0]   i_face_dir_x = '0;
    logic signed [cmtg_pkg::DIR_W-1:0]   i_face_dir_y = '0;
    logic signed [cmtg_pkg::DIR_W-1:0]   i_face_dir_z = '0;
    logic signed [cmtg_pkg::DIR_W-1:0]   i_vert_dir_x = '0;
    logic signed [cmtg_pkg::DIR_W-1:0]   i_vert_dir_y = '0;
    logic signed [cmtg_pkg::DIR_W-1:0]   i_vert_dir_z = '0;
    logic                                o_out_valid;
    logic                                i_out_ready = 1'b0;
    logic signed [cmtg_pkg::COORD_W-1:0] o_u_coord;
    logic signed [cmtg_pkg::COORD_W-1:0] o_v_coord;
    logic [cmtg_pkg::FACE_W-1:0]         o_cube_face;
    logic                                o_zero_major;

    t_coord                     coord_q[$];
    logic [cmtg_pkg::RES_W-1:0] res_now = cmtg_pkg::RES_RESET;
    bit                         bursts_on = 1'b1;
    bit                         hold_req = 1'b0;
    int                         err_cnt = 0;

    cube_map_texcoord_generator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_face_dir_x (i_face_dir_x),
        .i_face_dir_y (i_face_dir_y),
        .i_face_dir_z (i_face_dir_z),
        .i_vert_dir_x (i_vert_dir_x),
        .i_vert_dir_y (i_vert_dir_y),
        .i_vert_dir_z (i_vert_dir_z),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_u_coord    (o_u_coord),
        .o_v_coord    (o_v_coord),
        .o_cube_face  (o_cube_face),
        .o_zero_major (o_zero_major)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // round (c+mag)*scale*128/mag to nearest, halves up, then saturate
    function automatic logic [cmtg_pkg::COORD_W-1:0] coord_round(
        longint c, longint mag, longint scale);
        longint num;
        longint n2;
        longint d2;
        longint q;
        num = (c + mag) * scale * 128;
        n2  = 2 * num + mag;
        d2  = 2 * mag;
        q   = n2 / d2;
        if ((n2 % d2) != 0 && n2 < 0)
            q = q - 1;
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        return q[cmtg_pkg::COORD_W-1:0];
    endfunction

    function automatic t_coord texcoord_predict(
        logic signed [cmtg_pkg::DIR_W-1:0] fx, logic signed [cmtg_pkg::DIR_W-1:0] fy,
        logic signed [cmtg_pkg::DIR_W-1:0] fz, logic signed [cmtg_pkg::DIR_W-1:0] vx,
        logic signed [cmtg_pkg::DIR_W-1:0] vy, logic signed [cmtg_pkg::DIR_W-1:0] vz,
        logic [cmtg_pkg::RES_W-1:0] scale);
        longint cand[cmtg_pkg::N_FACES];
        longint best;
        longint x, y, z, sc, tc, ma;
        int     idx;
        t_coord r;
        cand[0] = longint'(fx);  cand[1] = -longint'(fx);
        cand[2] = longint'(fy);  cand[3] = -longint'(fy);
        cand[4] = longint'(fz);  cand[5] = -longint'(fz);
        best = 0;
        idx  = 0;
        for (int i = 0; i < cmtg_pkg::N_FACES; i++) begin
            if (cand[i] > best) begin
                best = cand[i];
                idx  = i;
            end
        end
        x = longint'(vx);
        y = longint'(vy);
        z = longint'(vz);
        r.face = cmtg_pkg::t_face'(idx);
        case (r.face)
            cmtg_pkg::FACE_PX: begin sc = -z; tc = -y; ma = x; end
            cmtg_pkg::FACE_NX: begin sc =  z; tc = -y; ma = x; end
            cmtg_pkg::FACE_PY: begin sc =  x; tc =  z; ma = y; end
            cmtg_pkg::FACE_NY: begin sc =  x; tc = -z; ma = y; end
            cmtg_pkg::FACE_PZ: begin sc =  x; tc = -y; ma = z; end
            default: begin sc = -x; tc = -y; ma = z; end
        endcase
        if (ma < 0)
            ma = -ma;
        if (ma == 0) begin
            r.u    = '0;
            r.v    = '0;
            r.zero = 1'b1;
        end else begin
            r.u    = coord_round(sc, ma, longint'(scale));
            r.v    = coord_round(tc, ma, longint'(scale));
            r.zero = 1'b0;
        end
        return r;
    endfunction

    task automatic send_dirs(
        logic signed [cmtg_pkg::DIR_W-1:0] fx, logic signed [cmtg_pkg::DIR_W-1:0] fy,
        logic signed [cmtg_pkg::DIR_W-1:0] fz, logic signed [cmtg_pkg::DIR_W-1:0] vx,
        logic signed [cmtg_pkg::DIR_W-1:0] vy, logic signed [cmtg_pkg::DIR_W-1:0] vz);
        if (bursts_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_face_dir_x <= fx;
        i_face_dir_y <= fy;
        i_face_dir_z <= fz;
        i_vert_dir_x <= vx;
        i_vert_dir_y <= vy;
        i_vert_dir_z <= vz;
        do @(posedge i_clk); while (!o_in_ready);
        coord_q = {coord_q, texcoord_predict(fx, fy, fz, vx, vy, vz, res_now)};
    endtask

    function automatic logic signed [cmtg_pkg::DIR_W-1:0] rand_dir();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0: return -16'sd32768;
                    1: return 16'sd32767;
                    2: return 16'sd16384;
                    3: return -16'sd16384;
                    4: return 16'sd1;
                    default: return 16'sd0;
                endcase
            end
            1, 2: return cmtg_pkg::DIR_W'($urandom());
            default: return cmtg_pkg::DIR_W'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    task automatic send_random_item();
        logic signed [cmtg_pkg::DIR_W-1:0] f[3];
        logic signed [cmtg_pkg::DIR_W-1:0] v[3];
        int k;
        for (int i = 0; i < 3; i++)
            v[i] = rand_dir();
        k = $urandom_range(0, 2);
        case ($urandom_range(0, 19))
            0: begin
                // axis-aligned face, vertex major component zero
                f = '{0, 0, 0};
                f[k] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
                v[k] = '0;
            end
            1, 2: begin
                // ties between faces
                for (int i = 0; i < 3; i++) begin
                    case ($urandom_range(0, 3))
                        0: f[i] = 16'sd8192;
                        1: f[i] = -16'sd8192;
                        default: f[i] = '0;
                    endcase
                end
            end
            3, 4, 5, 6, 7: begin
                for (int i = 0; i < 3; i++)
                    f[i] = rand_dir();
            end
            default: f = v;
        endcase
        send_dirs(f[0], f[1], f[2], v[0], v[1], v[2]);
    endtask

    task automatic write_res_factor(logic [cmtg_pkg::RES_W-1:0] value);
        i_in_valid <= 1'b0;
        while (coord_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        res_now = value;
    endtask

    task automatic test_faces_at_reset_scale();
        send_dirs(16384, 0, 0, 16384, 0, 0);
        send_dirs(-16384, 0, 0, -16384, 4000, -3000);
        send_dirs(0, 16384, 0, 1000, 16384, -2000);
        send_dirs(0, -16384, 0, -1500, -16384, 7000);
        send_dirs(0, 0, 16384, 9000, -9000, 16384);
        send_dirs(0, 0, -16384, -5000, 3000, -16384);
        send_dirs(8192, 8192, 0, 8192, 8192, 100);
        send_dirs(-8192, 0, 8192, -8192, 10, 8192);
        send_dirs(0, 8192, -8192, 20, 8192, -8192);
        send_dirs(0, 0, 0, 5, 6, 7);
        send_dirs(-8192, -8192, -8192, -8192, -8192, -8192);
        send_dirs(16384, 0, 0, 0, 100, 200);
        send_dirs(0, 0, 0, 0, 0, 0);
        send_dirs(0, -16384, 0, 300, 0, -400);
        send_dirs(-32768, 0, 0, -32768, 32767, -32768);
        send_dirs(32767, 32767, 32767, 32767, 32767, 32767);
        send_dirs(-32768, -32768, -32768, 1, -32768, 32767);
        send_dirs(0, 0, 16384, 32767, -32768, 1);
        send_dirs(0, 0, -16384, 16384, 16384, -16384);
        send_dirs(16384, 0, 0, 16384, -16384, 16384);
    endtask

    task automatic test_scale_extremes();
        logic [cmtg_pkg::RES_W-1:0] scales[4];
        scales = '{16'd0, 16'hffff, 16'd1, 16'd257};
        foreach (scales[s]) begin
            write_res_factor(scales[s]);
            send_dirs(0, 0, 16384, 32767, 0, 1);
            send_dirs(0, 0, 16384, -32768, 32767, 1);
            send_dirs(16384, 0, 0, -32768, 0, -32768);
            send_dirs(16384, 0, 0, 16384, 0, 0);
            send_dirs(0, 16384, 0, 3, 7, 0);
            repeat (40) send_random_item();
        end
    endtask

    task automatic test_random_stream();
        for (int p = 0; p < 5; p++) begin
            write_res_factor(p == 0 ? cmtg_pkg::RES_RESET : cmtg_pkg::RES_W'($urandom()));
            for (int n = 0; n < 300; n++) begin
                if (n % 100 == 0)
                    bursts_on = ($urandom_range(0, 2) != 0);
                send_random_item();
            end
        end
        bursts_on = 1'b1;
    endtask

    task automatic test_output_hold();
        write_res_factor(16'd512);
        hold_req = 1'b1;
        repeat (100) send_random_item();
    endtask

    task automatic test_full_rate();
        write_res_factor(16'hffff);
        bursts_on = 1'b0;
        repeat (150) send_random_item();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_faces_at_reset_scale();
        test_scale_extremes();
        test_random_stream();
        test_output_hold();
        test_full_rate();
        i_in_valid <= 1'b0;
        while (coord_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("cube_map_texcoord_generator test passed");
        end else begin
            $display("cube_map_texcoord_generator test failed");
        end
        $finish;
    end

    // receiver: random stalls plus one long hold on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_ready <= 1'b1;
                hold_req = 1'b0;
            end else if (bursts_on && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_coord e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (coord_q.size() == 0) begin
                $display("%0t: unexpected result beat u=%0d v=%0d face=%0d zero=%0d",
                         $time, o_u_coord, o_v_coord, o_cube_face, o_zero_major);
                err_cnt++;
            end else begin
                e = coord_q.pop_front();
                if (o_u_coord !== e.u) begin
                    $display("%0t: u_coord expected %0d actual %0d", $time, e.u, o_u_coord);
                    err_cnt++;
                end
                if (o_v_coord !== e.v) begin
                    $display("%0t: v_coord expected %0d actual %0d", $time, e.v, o_v_coord);
                    err_cnt++;
                end
                if (o_cube_face !== e.face) begin
                    $display("%0t: cube_face expected %0d actual %0d",
                             $time, e.face, o_cube_face);
                    err_cnt++;
                end
                if (o_zero_major !== e.zero) begin
                    $display("%0t: zero_major expected %0d actual %0d",
                             $time, e.zero, o_zero_major);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: watchdog expired", $time);
        $display("cube_map_texcoord_generator test failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/cmtg_pkg.sv
hdl/cmtg_face_sel.sv
hdl/cmtg_scale.sv
hdl/cmtg_div_lane.sv
hdl/cube_map_texcoord_generator.sv
bench/cube_map_texcoord_generator_tb.sv
